FILE: hw/rtl/khc_pkg.sv
// ---------------------------------------------------------------------------
// khc_pkg
// Shared constants for the k-mer histogram counter: field widths, stream
// packing, operation codes and parameter defaults.
// ---------------------------------------------------------------------------
package khc_pkg;

    localparam int KMER_LEN_DEF   = 10;
    localparam int COUNT_BITS_DEF = 32;

    // fixed field widths
    localparam int BASE_W   = 2;
    localparam int LOOKUP_W = 20;
    localparam int KIDX_W   = 20;
    localparam int COUNT_W  = 32;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

FILE: hw/rtl/khc_front.sv
// ---------------------------------------------------------------------------
// khc_front
// Base window and fill tracking; turns each accepted item into a queue entry
// (read request or count update) or drops it while the window is partial.
// ---------------------------------------------------------------------------
module khc_front #(
    parameter int KMER_LEN = khc_pkg::KMER_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        operation,
    input  logic [khc_pkg::BASE_W-1:0]  base_code,
    input  logic                        segment_start,
    input  logic                        sample_select,
    input  logic [khc_pkg::LOOKUP_W-1:0] lookup_index,
    output logic                        push,
    output logic [2*KMER_LEN+1:0]       entry
);
    import khc_pkg::*;

    localparam int WIN_W = 2 * KMER_LEN;
    localparam int FILL_W = $clog2(KMER_LEN + 1);
    localparam int LK_W = (WIN_W < LOOKUP_W) ? WIN_W : LOOKUP_W;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(KMER_LEN);

    logic [WIN_W-1:0]  window_reg;
    logic [WIN_W-1:0]  window_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_base;
    logic [WIN_W-1:0]  read_kmer;
    logic              is_read;

    assign is_read     = (operation == OP_READ);
    assign window_next = {window_reg[WIN_W-3:0], base_code};
    assign fill_base   = segment_start ? '0 : fill_reg;
    assign fill_next   = (fill_base < FILL_FULL) ? fill_base + 1'b1 : fill_base;
    assign read_kmer   = WIN_W'(lookup_index[LK_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept && !is_read)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

    // entry: {is_read, bank, kmer}
    always_comb
    begin
        if (is_read)
        begin
            push  = accept;
            entry = {1'b1, sample_select, read_kmer};
        end
        else
        begin
            push  = accept && (fill_next == FILL_FULL);
            entry = {1'b0, sample_select, window_next};
        end
    end

endmodule

FILE: hw/rtl/khc_queue.sv
// ---------------------------------------------------------------------------
// khc_queue
// Small FIFO decoupling the classifying front from the count-store back.
// ---------------------------------------------------------------------------
module khc_queue #(
    parameter int WIDTH = 22,
    parameter int DEPTH = khc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    import khc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/khc_back.sv
// ---------------------------------------------------------------------------
// khc_back
// Count store with clearing pass, read-modify-write with write forwarding,
// saturation and the output register.
// ---------------------------------------------------------------------------
module khc_back #(
    parameter int KMER_LEN   = khc_pkg::KMER_LEN_DEF,
    parameter int COUNT_BITS = khc_pkg::COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  logic [2*KMER_LEN+1:0]        head_data,
    output logic                         pop,
    output logic                         clearing,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_is_read,
    output logic [khc_pkg::KIDX_W-1:0]   out_kmer,
    output logic [khc_pkg::COUNT_W-1:0]  out_count
);
    import khc_pkg::*;

    localparam int WIN_W  = 2 * KMER_LEN;
    localparam int ADDR_W = WIN_W + 1;
    localparam longint unsigned MEM_DEPTH = 64'd1 << ADDR_W;
    localparam int IX_W   = (WIN_W > KIDX_W) ? WIN_W : KIDX_W;
    localparam int CX_W   = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;
    localparam logic [CX_W-1:0] OUT_MAX = CX_W'({COUNT_W{1'b1}});

    logic [COUNT_BITS-1:0] mem [0:MEM_DEPTH-1];
    logic [COUNT_BITS-1:0] rdata_reg;

    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    logic              s1_read_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_go;

    logic                  fwd_valid_reg;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic                  out_valid_reg;
    logic                  out_is_read_reg;
    logic [KIDX_W-1:0]     out_kmer_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] old_count;
    logic [COUNT_BITS-1:0] new_count;
    logic [COUNT_BITS-1:0] result_count;
    logic [CX_W-1:0]       count_ext;
    logic [IX_W-1:0]       kmer_ext;

    assign clearing = clearing_reg;
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop      = head_valid && !clearing_reg && (!s1_valid_reg || s1_go);
    assign rd_en    = pop;
    assign rd_addr  = head_data[ADDR_W-1:0];

    // the write landing at the same edge as this item's read is not in rdata
    assign old_count = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg
                                                                      : rdata_reg;
    assign new_count = (old_count == '1) ? old_count : old_count + 1'b1;
    assign result_count = s1_read_reg ? old_count : new_count;

    assign wr_en   = clearing_reg || (s1_go && !s1_read_reg);
    assign wr_addr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign wr_data = clearing_reg ? '0 : new_count;

    assign count_ext = CX_W'(result_count);
    assign kmer_ext  = IX_W'(s1_addr_reg[WIN_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                    clearing_reg <= 1'b0;
            end

            if (pop)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go && !s1_read_reg)
                fwd_valid_reg <= 1'b1;

            if (s1_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_read_reg <= head_data[ADDR_W];
            s1_addr_reg <= head_data[ADDR_W-1:0];
        end
        if (s1_go && !s1_read_reg)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_count;
        end
        if (s1_go)
        begin
            out_is_read_reg <= s1_read_reg;
            out_kmer_reg    <= kmer_ext[KIDX_W-1:0];
            out_count_reg   <= (count_ext > OUT_MAX) ? '1 : count_ext[COUNT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_is_read = out_is_read_reg;
    assign out_kmer    = out_kmer_reg;
    assign out_count   = out_count_reg;

endmodule

FILE: hw/rtl/kmer_histogram_counter.sv
// ---------------------------------------------------------------------------
// kmer_histogram_counter
// Counts k-mers of streamed 2-bit bases in two banks (experiment / control)
// and answers count reads.
// ---------------------------------------------------------------------------
//  Channel | Direction | tdata (low bit up)              | tuser (low bit up)
//  --------+-----------+---------------------------------+-------------------------------
//  s_*     | in        | base_code[1:0], lookup_index    | operation, segment_start,
//          |           | [21:2], zero pad to 24 bits     | sample_select
//  m_*     | out       | kmer_index[19:0], count_value   | is_read_reply
//          |           | [51:20], zero pad to 56 bits    |
//
// One item per cycle sustained while m_tready is high; a result passes the queue
// write at the edge that accepts its item, then the registered count-store read
// and the output register before it is offered. Same-address updates in
// consecutive cycles are forwarded.
// After reset the count store is cleared one entry per cycle, all
// 2^(2*KMER_LEN+1) entries (2,097,152 at KMER_LEN = 10), s_tready low meanwhile.
// m_tready low stalls the back end; the queue keeps s_tready high until full.
// ---------------------------------------------------------------------------
module kmer_histogram_counter #(
    parameter int KMER_LEN   = khc_pkg::KMER_LEN_DEF,
    parameter int COUNT_BITS = khc_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // base_code[1:0], lookup_index[21:2], pad
    input  logic [khc_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[0], segment_start[1], sample_select[2]
    input  logic [khc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // kmer_index[19:0], count_value[51:20], pad
    output logic [khc_pkg::M_TDATA_W-1:0]   m_tdata,
    // is_read_reply[0]
    output logic [khc_pkg::M_TUSER_W-1:0]   m_tuser
);
    import khc_pkg::*;

    localparam int ENTRY_W = 2 * KMER_LEN + 2;

    logic               accept;
    logic               q_push;
    logic [ENTRY_W-1:0] q_entry;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_head;
    logic               clearing;
    logic               out_is_read;
    logic [KIDX_W-1:0]  out_kmer;
    logic [COUNT_W-1:0] out_count;

    assign s_tready = !q_full && !clearing;
    assign accept   = s_tvalid && s_tready;

    khc_front #(
        .KMER_LEN (KMER_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (s_tuser[0]),
        .base_code     (s_tdata[1:0]),
        .segment_start (s_tuser[1]),
        .sample_select (s_tuser[2]),
        .lookup_index  (s_tdata[21:2]),
        .push          (q_push),
        .entry         (q_entry)
    );

    khc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    khc_back #(
        .KMER_LEN   (KMER_LEN),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head_data   (q_head),
        .pop         (q_pop),
        .clearing    (clearing),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_is_read (out_is_read),
        .out_kmer    (out_kmer),
        .out_count   (out_count)
    );

    assign m_tdata = {4'b0000, out_count, out_kmer};
    assign m_tuser = out_is_read;

endmodule

FILE: hw/rtl/khc_checker.sv
// ---------------------------------------------------------------------------
// khc_checker
// Port-level checks for the k-mer histogram counter, bound to the top level.
// ---------------------------------------------------------------------------
module khc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [khc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [khc_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [khc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [khc_pkg::M_TUSER_W-1:0] m_tuser
);
    import khc_pkg::*;

    // store is being cleared right after reset
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("input ready during clearing pass");

    // an update always reports a nonzero count
    a_update_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == 1'b0) |-> (m_tdata[51:20] != '0))
        else $error("count update reported zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("output item changed while stalled");

endmodule

bind kmer_histogram_counter khc_checker u_khc_checker (.*);

FILE: tb/tb_kmer_histogram_counter.sv
// ---------------------------------------------------------------------------
// tb_kmer_histogram_counter
// Self-checking bench for the k-mer histogram counter. Streams pushes and
// count reads into the block with random idle bursts on both sides. A local
// model of the base window and both count banks predicts each update and
// read reply, and every output item is checked in order, field by field.
// ---------------------------------------------------------------------------
module tb_kmer_histogram_counter;

    timeunit 1ns;
    timeprecision 1ps;

    import khc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int KMER_LEN     = KMER_LEN_DEF;
    localparam int WIN_W        = 2 * KMER_LEN;
    localparam int RANDOM_ITEMS = 1250;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic                operation;
        logic [BASE_W-1:0]   base_code;
        logic                segment_start;
        logic                sample_select;
        logic [LOOKUP_W-1:0] lookup_index;
    } dna_item_t;

    typedef struct packed {
        logic               is_read_reply;
        logic [KIDX_W-1:0]  kmer_index;
        logic [COUNT_W-1:0] count_value;
    } count_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // stimulus and prediction state
    dna_item_t      pending_items[$];
    dna_item_t      cur_item;
    count_reply_t   expected_counts[$];
    logic [COUNT_W-1:0] kmer_counts[logic [WIN_W:0]];   // key: {bank, kmer}
    logic [WIN_W-1:0]   win_bases = '0;
    int                 win_fill = 0;

    // generator-side view of the window, only used to aim reads at live k-mers
    logic [WIN_W:0]   recent_keys[$];
    logic [WIN_W-1:0] gen_win = '0;
    int               gen_fill = 0;

    bit  in_fire = 1'b0;
    int  items_in = 0;
    int  total_items = 0;
    int  fail_count = 0;
    int  send_idle = 0;
    int  ready_hold = 0;
    bit  long_hold_done = 1'b0;

    kmer_histogram_counter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // advances the window and count banks by one accepted item
    task automatic update_kmer_counts(input dna_item_t it);
        count_reply_t       r;
        logic [WIN_W:0]     key;
        logic [COUNT_W-1:0] cnt;
        if (it.operation == OP_READ)
        begin
            // base_code and segment_start play no part in a read
            key = {it.sample_select, it.lookup_index[WIN_W-1:0]};
            r.is_read_reply = 1'b1;
            r.kmer_index    = it.lookup_index[WIN_W-1:0];
            r.count_value   = kmer_counts.exists(key) ? kmer_counts[key] : '0;
            expected_counts.push_back(r);
        end
        else
        begin
            if (it.segment_start)
                win_fill = 0;
            win_bases = {win_bases[WIN_W-3:0], it.base_code};
            if (win_fill < KMER_LEN)
                win_fill++;
            if (win_fill == KMER_LEN)
            begin
                key = {it.sample_select, win_bases};
                cnt = kmer_counts.exists(key) ? kmer_counts[key] : '0;
                // counter width equals the output field, so only the counter saturates
                if (cnt != '1)
                    cnt++;
                kmer_counts[key] = cnt;
                r.is_read_reply = 1'b0;
                r.kmer_index    = win_bases;
                r.count_value   = cnt;
                expected_counts.push_back(r);
            end
        end
    endtask

    task automatic add_push(input logic [1:0] base, input bit start, input bit sel);
        dna_item_t it;
        it.operation     = OP_PUSH;
        it.base_code     = base;
        it.segment_start = start;
        it.sample_select = sel;
        it.lookup_index  = LOOKUP_W'($urandom_range(0, 2 ** LOOKUP_W - 1));
        pending_items.push_back(it);
        if (start)
            gen_fill = 0;
        gen_win = {gen_win[WIN_W-3:0], base};
        if (gen_fill < KMER_LEN)
            gen_fill++;
        if (gen_fill == KMER_LEN)
        begin
            recent_keys.push_back({sel, gen_win});
            if (recent_keys.size() > 64)
                void'(recent_keys.pop_front());
        end
    endtask

    task automatic add_read(input logic [LOOKUP_W-1:0] idx, input bit sel,
                            input logic [1:0] base, input bit start);
        dna_item_t it;
        it.operation     = OP_READ;
        it.base_code     = base;
        it.segment_start = start;
        it.sample_select = sel;
        it.lookup_index  = idx;
        pending_items.push_back(it);
    endtask

    task automatic add_random_read();
        logic [WIN_W:0] key;
        if (recent_keys.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            // sometimes ask the other bank for the same k-mer
            if ($urandom_range(0, 3) == 0)
                key[WIN_W] = ~key[WIN_W];
            add_read(key[WIN_W-1:0], key[WIN_W], 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
        end
        else
        begin
            add_read(LOOKUP_W'($urandom_range(0, 2 ** LOOKUP_W - 1)),
                     1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic bit in_tail();
        return items_in + TAIL_ITEMS >= total_items;
    endfunction

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_fire)
            begin
                // hold the offered item until it is taken
            end
            else if (send_idle > 0)
            begin
                s_tvalid <= 1'b0;
                send_idle--;
            end
            else if (!in_tail() && $urandom_range(0, 9) == 0)
            begin
                s_tvalid <= 1'b0;
                send_idle = $urandom_range(0, 13);
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, cur_item.lookup_index, cur_item.base_code};
                s_tuser  <= {cur_item.sample_select, cur_item.segment_start,
                             cur_item.operation};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && items_in >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                ready_hold = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (ready_hold > 0)
            begin
                ready_hold--;
                m_tready <= 1'b0;
            end
            else if (!in_tail() && $urandom_range(0, 7) == 0)
            begin
                ready_hold = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on input handshakes, check on output handshakes
    always @(posedge clk)
    begin
        count_reply_t got;
        count_reply_t want;
        in_fire = s_tvalid && s_tready;
        if (in_fire)
        begin
            update_kmer_counts(cur_item);
            items_in++;
        end
        if (m_tvalid && m_tready)
        begin
            got.is_read_reply = m_tuser[0];
            got.kmer_index    = m_tdata[KIDX_W-1:0];
            got.count_value   = m_tdata[KIDX_W +: COUNT_W];
            if (expected_counts.size() == 0)
            begin
                report_mismatch("unexpected item", 64'(got), '0);
            end
            else
            begin
                want = expected_counts.pop_front();
                if (got.is_read_reply !== want.is_read_reply)
                    report_mismatch("is_read_reply", 64'(got.is_read_reply),
                                    64'(want.is_read_reply));
                if (got.kmer_index !== want.kmer_index)
                    report_mismatch("kmer_index", 64'(got.kmer_index),
                                    64'(want.kmer_index));
                if (got.count_value !== want.count_value)
                    report_mismatch("count_value", 64'(got.count_value),
                                    64'(want.count_value));
            end
        end
    end

    initial
    begin
        int          seg_len;
        int          mode;
        int          motif_len;
        int          kind;
        logic [7:0]  motif;
        logic [1:0]  base;
        bit          sel;

        // directed: all-T k-mer twice in the experiment bank, partial windows
        add_push(2'd3, 1'b1, 1'b0);
        repeat (10)
            add_push(2'd3, 1'b0, 1'b0);
        // new segment on a full window: restart, then all-A k-mer in the control bank
        add_push(2'd0, 1'b1, 1'b1);
        repeat (9)
            add_push(2'd0, 1'b0, 1'b1);
        add_read({LOOKUP_W{1'b1}}, 1'b0, 2'd0, 1'b0);
        add_read({LOOKUP_W{1'b1}}, 1'b1, 2'd2, 1'b0);
        add_read('0, 1'b1, 2'd1, 1'b1);
        add_read('0, 1'b0, 2'd3, 1'b1);

        // random: mostly well-formed segments, some broken ones and bare reads
        while (pending_items.size() < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                seg_len   = $urandom_range(KMER_LEN, 4 * KMER_LEN);
                sel       = 1'($urandom_range(0, 1));
                mode      = $urandom_range(0, 2);
                motif     = 8'($urandom_range(0, 255));
                motif_len = $urandom_range(1, 4);
                for (int i = 0; i < seg_len; i++)
                begin
                    // repeating motifs make k-mers recur so counts climb
                    if (mode == 0 || $urandom_range(0, 7) == 0)
                        base = 2'($urandom_range(0, 3));
                    else
                        base = motif[2 * (i % motif_len) +: 2];
                    add_push(base, i == 0, ($urandom_range(0, 15) == 0) ? ~sel : sel);
                    if ($urandom_range(0, 7) == 0)
                        add_random_read();
                end
            end
            else if (kind < 9)
            begin
                seg_len = $urandom_range(1, KMER_LEN - 1);
                sel     = 1'($urandom_range(0, 1));
                for (int i = 0; i < seg_len; i++)
                    add_push(2'($urandom_range(0, 3)), (i == 0) && $urandom_range(0, 1), sel);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    add_random_read();
            end
        end
        total_items = pending_items.size();

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // the block clears its count store before it takes items
        while (items_in < total_items) @(negedge clk);
        while (expected_counts.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // allow several times the slowest run, store clear included
    initial
    begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

endmodule
